// ----- hdl/hwss_pkg.sv -----
// Shared types, register indexes, datapath op codes and sine polynomial constants.
`default_nettype none

package hwss_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_BASE_PHASE   = 3'd0;
    localparam logic [2:0] REG_HARM_COUNT   = 3'd1;
    localparam logic [2:0] REG_AMP_SECOND   = 3'd2;
    localparam logic [2:0] REG_AMP_THIRD    = 3'd3;
    localparam logic [2:0] REG_AMP_FOURTH   = 3'd4;
    localparam logic [2:0] REG_PHASE_SECOND = 3'd5;
    localparam logic [2:0] REG_PHASE_THIRD  = 3'd6;
    localparam logic [2:0] REG_PHASE_FOURTH = 3'd7;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_RAMP  = 4'd2;
    localparam logic [3:0] OP_PHASE = 4'd3;
    localparam logic [3:0] OP_USQ   = 4'd4;
    localparam logic [3:0] OP_U2    = 4'd5;
    localparam logic [3:0] OP_HMUL  = 4'd6;
    localparam logic [3:0] OP_HSUB  = 4'd7;
    localparam logic [3:0] OP_SMUL  = 4'd8;
    localparam logic [3:0] OP_SQ    = 4'd9;
    localparam logic [3:0] OP_AMUL  = 4'd10;
    localparam logic [3:0] OP_ACC   = 4'd11;
    localparam logic [3:0] OP_DSET  = 4'd12;
    localparam logic [3:0] OP_DIV   = 4'd13;
    localparam logic [3:0] OP_OUT   = 4'd14;

    // Fundamental weight, 1.0 in Q4.12.
    localparam logic [15:0] AMP_UNITY = 16'd4096;

    // Odd polynomial coefficients for sin(pi/2 * u), Q30.
    localparam logic [30:0] POLY_C9 = 31'd172272;
    localparam logic [30:0] POLY_HORNER [4] = '{
        31'd5026995, 31'd85569306, 31'd693598343, 31'd1686629713
    };

    typedef struct packed {
        logic [15:0]      base_phase;
        logic [1:0]       harm_count;
        logic [2:0][15:0] amp;
        logic [2:0][15:0] phase;
    } t_cfg;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] order;
        logic [1:0] hstep;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- hdl/hwss_regs.sv -----
// Configuration register file written through the configuration channel.
`default_nettype none

module hwss_regs
    import hwss_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BASE_PHASE:   r_cfg.base_phase <= i_cfg_data;
                REG_HARM_COUNT:   r_cfg.harm_count <= i_cfg_data[1:0];
                REG_AMP_SECOND:   r_cfg.amp[0]     <= i_cfg_data;
                REG_AMP_THIRD:    r_cfg.amp[1]     <= i_cfg_data;
                REG_AMP_FOURTH:   r_cfg.amp[2]     <= i_cfg_data;
                REG_PHASE_SECOND: r_cfg.phase[0]   <= i_cfg_data;
                REG_PHASE_THIRD:  r_cfg.phase[1]   <= i_cfg_data;
                REG_PHASE_FOURTH: r_cfg.phase[2]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/hwss_ctrl.sv -----
// Controller state machine sequencing the shared multiplier and the divider.
`default_nettype none

module hwss_ctrl
    import hwss_pkg::*;
#(
    parameter int HARM_LIMIT = 3
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_harm_count,
    input  t_dp_status      i_status,
    output t_dp_cmd         o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RAMP  = 4'd1;
    localparam logic [3:0] S_PHASE = 4'd2;
    localparam logic [3:0] S_USQ   = 4'd3;
    localparam logic [3:0] S_U2    = 4'd4;
    localparam logic [3:0] S_HMUL  = 4'd5;
    localparam logic [3:0] S_HSUB  = 4'd6;
    localparam logic [3:0] S_SMUL  = 4'd7;
    localparam logic [3:0] S_SQ    = 4'd8;
    localparam logic [3:0] S_AMUL  = 4'd9;
    localparam logic [3:0] S_ACC   = 4'd10;
    localparam logic [3:0] S_DSET  = 4'd11;
    localparam logic [3:0] S_DIV   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    localparam logic [1:0] MAX_ORDER = 2'(HARM_LIMIT);

    logic [3:0] r_state, n_state;
    logic [1:0] r_order, n_order;
    logic [1:0] r_hstep, n_hstep;
    logic [3:0] r_dcnt,  n_dcnt;
    logic [1:0] last_order;
    logic       accept;

    assign last_order = (i_harm_count > MAX_ORDER) ? MAX_ORDER : i_harm_count;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        n_state     = r_state;
        n_order     = r_order;
        n_hstep     = r_hstep;
        n_dcnt      = r_dcnt;
        o_cmd.op    = OP_NONE;
        o_cmd.order = r_order;
        o_cmd.hstep = r_hstep;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.op = OP_LOAD;
                    n_order  = 2'd0;
                    n_state  = S_RAMP;
                end
            end
            S_RAMP: begin
                o_cmd.op = OP_RAMP;
                n_state  = S_PHASE;
            end
            S_PHASE: begin
                o_cmd.op = OP_PHASE;
                n_state  = S_USQ;
            end
            S_USQ: begin
                o_cmd.op = OP_USQ;
                n_state  = S_U2;
            end
            S_U2: begin
                o_cmd.op = OP_U2;
                n_hstep  = 2'd0;
                n_state  = S_HMUL;
            end
            S_HMUL: begin
                o_cmd.op = OP_HMUL;
                n_state  = S_HSUB;
            end
            S_HSUB: begin
                o_cmd.op = OP_HSUB;
                n_hstep  = r_hstep + 2'd1;
                n_state  = (r_hstep == 2'd3) ? S_SMUL : S_HMUL;
            end
            S_SMUL: begin
                o_cmd.op = OP_SMUL;
                n_state  = S_SQ;
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                n_state  = S_AMUL;
            end
            S_AMUL: begin
                o_cmd.op = OP_AMUL;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.op = OP_ACC;
                if (r_order == last_order) begin
                    n_state = S_DSET;
                end else begin
                    n_order = r_order + 2'd1;
                    n_state = S_RAMP;
                end
            end
            S_DSET: begin
                o_cmd.op = OP_DSET;
                n_dcnt   = 4'd0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                n_dcnt   = r_dcnt + 4'd1;
                if (r_dcnt == 4'd15) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // Hold the finished code until the output register is free.
                if (i_status.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_order <= 2'd0;
            r_hstep <= 2'd0;
            r_dcnt  <= 4'd0;
        end else begin
            r_state <= n_state;
            r_order <= n_order;
            r_hstep <= n_hstep;
            r_dcnt  <= n_dcnt;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/hwss_datapath.sv -----
// Datapath: phase ramp, polynomial sine, weighted sum, restoring divider, output register.
`default_nettype none

module hwss_datapath
    import hwss_pkg::*;
#(
    parameter int WAVE_LEN        = 1024,
    parameter int SINE_TABLE_BITS = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  t_cfg             i_cfg,
    input  wire logic [9:0]  i_index,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [15:0]      o_out_code,
    output t_dp_status       o_status
);

    // floor(n * 65536 / WAVE_LEN) for n < 4096 is an exact reciprocal multiply.
    localparam int WL_BITS      = $clog2(WAVE_LEN);
    localparam int RECIP_SHIFT  = 28 + WL_BITS;
    localparam int RAMP_LSB     = RECIP_SHIFT - 16;
    localparam logic [30:0] RECIP = 31'((64'd1 << RECIP_SHIFT) / WAVE_LEN + 64'd1);
    localparam int POS_BITS     = SINE_TABLE_BITS - 2;
    localparam int POS_SHIFT    = 16 - POS_BITS;

    logic [9:0]         r_idx;
    logic [47:0]        r_prod;
    logic [16:0]        r_u;
    logic [16:0]        r_u2;
    logic [30:0]        r_p;
    logic [14:0]        r_q;
    logic               r_neg;
    logic signed [33:0] r_acc;
    logic [17:0]        r_den;
    logic [47:0]        r_rem;
    logic [47:0]        r_dsh;
    logic [15:0]        r_quot;
    logic               r_dneg;
    logic [15:0]        r_code;
    logic               r_out_valid;

    logic [2:0]                   k;
    logic [11:0]                  n;
    logic [15:0]                  amp;
    logic [15:0]                  offset;
    logic [16:0]                  mul_a;
    logic [30:0]                  mul_b;
    logic [47:0]                  mul_p;
    logic [15:0]                  ph;
    logic [SINE_TABLE_BITS-1:0]   tidx;
    logic [POS_BITS-1:0]          pos;
    logic [16:0]                  u0;
    logic [16:0]                  u_n;
    logic [30:0]                  s_val;
    logic [46:0]                  sq_t;
    logic [16:0]                  q_raw;
    logic [14:0]                  q_n;
    logic signed [33:0]           term;
    logic signed [33:0]           acc_neg;
    logic [32:0]                  mag;
    logic [32:0]                  dd;
    logic [16:0]                  cdiv;
    logic [15:0]                  code_n;

    assign o_out_valid       = r_out_valid;
    assign o_out_code        = r_code;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        k = {1'b0, i_cmd.order} + 3'd1;
        n = 12'({2'b0, r_idx} * {9'b0, k});
        unique case (i_cmd.order)
            2'd0: begin
                amp    = AMP_UNITY;
                offset = i_cfg.base_phase;
            end
            2'd1: begin
                amp    = i_cfg.amp[0];
                offset = i_cfg.phase[0];
            end
            2'd2: begin
                amp    = i_cfg.amp[1];
                offset = i_cfg.phase[1];
            end
            default: begin
                amp    = i_cfg.amp[2];
                offset = i_cfg.phase[2];
            end
        endcase
    end

    // One shared multiplier serves the ramp, the polynomial and the weighting.
    always_comb begin
        unique case (i_cmd.op)
            OP_RAMP: begin
                mul_a = 17'(n);
                mul_b = RECIP;
            end
            OP_USQ: begin
                mul_a = r_u;
                mul_b = 31'(r_u);
            end
            OP_HMUL: begin
                mul_a = r_u2;
                mul_b = r_p;
            end
            OP_SMUL: begin
                mul_a = r_u;
                mul_b = r_p;
            end
            OP_AMUL: begin
                mul_a = {1'b0, amp};
                mul_b = 31'(r_q);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = {31'b0, mul_a} * {17'b0, mul_b};
    end

    // Quarter-wave folding of the truncated phase.
    always_comb begin
        ph   = r_prod[RAMP_LSB +: 16] + offset;
        tidx = ph[15 -: SINE_TABLE_BITS];
        pos  = tidx[POS_BITS-1:0];
        u0   = 17'(pos) << POS_SHIFT;
        u_n  = tidx[POS_BITS] ? (17'd65536 - u0) : u0;
    end

    // Scale to 32767 full scale with rounding, then clamp.
    always_comb begin
        s_val = r_prod[46:16];
        sq_t  = ({16'b0, s_val} << 15) - {16'b0, s_val} + (47'd1 << 29);
        q_raw = sq_t[46:30];
        q_n   = (q_raw > 17'd32767) ? 15'd32767 : q_raw[14:0];
    end

    always_comb begin
        term    = signed'({3'b0, r_prod[30:0]});
        acc_neg = -r_acc;
        mag     = r_acc[33] ? acc_neg[32:0] : r_acc[32:0];
        dd      = {r_den, 15'b0} - {15'b0, r_den};
    end

    // Negative quotients round toward minus infinity; a full negative swing
    // lands one below zero and saturates.
    always_comb begin
        cdiv = {1'b0, r_quot} + 17'(r_rem != 48'd0);
        if (r_dneg) begin
            code_n = (cdiv >= 17'd32768) ? 16'd0 : 16'(17'd32767 - cdiv);
        end else begin
            code_n = 16'(17'd32767 + {1'b0, r_quot});
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_idx <= i_index;
                r_acc <= '0;
                r_den <= '0;
            end
            OP_RAMP, OP_USQ, OP_HMUL, OP_SMUL, OP_AMUL: begin
                r_prod <= mul_p;
            end
            OP_PHASE: begin
                r_u   <= u_n;
                r_neg <= tidx[SINE_TABLE_BITS-1];
            end
            OP_U2: begin
                r_u2 <= r_prod[32:16];
                r_p  <= POLY_C9;
            end
            OP_HSUB: begin
                r_p <= POLY_HORNER[i_cmd.hstep] - r_prod[46:16];
            end
            OP_SQ: begin
                r_q <= q_n;
            end
            OP_ACC: begin
                r_acc <= r_neg ? (r_acc - term) : (r_acc + term);
                r_den <= r_den + {2'b0, amp};
            end
            OP_DSET: begin
                r_rem  <= {mag, 15'b0};
                r_dsh  <= {dd, 15'b0};
                r_dneg <= r_acc[33];
                r_quot <= '0;
            end
            OP_DIV: begin
                if (r_rem >= r_dsh) begin
                    r_rem  <= r_rem - r_dsh;
                    r_quot <= {r_quot[14:0], 1'b1};
                end else begin
                    r_quot <= {r_quot[14:0], 1'b0};
                end
                r_dsh <= {1'b0, r_dsh[47:1]};
            end
            OP_OUT: begin
                r_code <= code_n;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/harmonic_wave_sample_synth_top.sv -----
// Additive harmonic sine synthesizer: one offset-binary DAC code per sample index.
//
// Input stream: each beat carries a sample index within one WAVE_LEN-point period.
// The block sums the fundamental and up to HARM_LIMIT harmonics (orders 2..4),
// each with its own amplitude and phase, normalizes by one plus the amplitude sum
// and emits a 16-bit code (32767 is zero, saturated) on the output stream.
// Configuration beats may be written at any time the block is idle; the port is
// always ready.
// Each order runs as a sequence of steps on the one shared multiplier (ramp, fold,
// square, four Horner steps, sine scale, weighting, accumulate), and the
// normalizing divide yields one quotient bit per cycle. An input beat is taken
// only while the controller is idle, so a new sample index is not accepted until
// the previous result has been computed and moved to the output register.
// Results sit in an output register, so a new input beat is taken while the
// previous result still waits; if the receiver stalls longer, the next result
// waits inside the block and no further input is taken.
// Reset (synchronous, active low) returns the configuration registers to zero and
// the controller to idle, and empties the output register.
`default_nettype none

module harmonic_wave_sample_synth_top
    import hwss_pkg::*;
#(
    parameter int WAVE_LEN        = 1024,
    parameter int HARM_LIMIT      = 3,
    parameter int SINE_TABLE_BITS = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [9:0] sample_index, [15:10] zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] sample_code
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_cfg       cfg;
    t_dp_cmd    cmd;
    t_dp_status status;

    hwss_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    hwss_ctrl #(
        .HARM_LIMIT (HARM_LIMIT)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_harm_count (cfg.harm_count),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    hwss_datapath #(
        .WAVE_LEN        (WAVE_LEN),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (cfg),
        .i_index     (s_axis_tdata[9:0]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_code  (m_axis_tdata),
        .o_status    (status)
    );

endmodule

`default_nettype wire

// ----- test/harmonic_wave_sample_synth_top_test.sv -----
// Self-checking testbench for the additive harmonic sample synthesizer stream block.
`default_nettype none

module harmonic_wave_sample_synth_top_test;
    import hwss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WAVE_POINTS    = 1024;
    localparam int TABLE_BITS     = 12;
    localparam int HARMONIC_LIMIT = 3;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int TAIL_CYCLES    = 150;
    localparam int SEGMENTS       = 7;
    localparam int SEGMENT_ITEMS  = 50;

    // Keeps its own copy of the voice registers and the codes still owed by the block.
    class synth_scoreboard;
        logic [15:0] base_phase;
        logic [1:0]  harm_count;
        logic [15:0] amp [3];
        logic [15:0] phs [3];
        logic [15:0] owed_codes [$];
        int          errors;

        function new();
            base_phase = '0;
            harm_count = '0;
            for (int k = 0; k < 3; k++) begin
                amp[k] = '0;
                phs[k] = '0;
            end
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] index, logic [15:0] value);
            case (index)
                REG_BASE_PHASE:   base_phase = value;
                REG_HARM_COUNT:   harm_count = value[1:0];
                REG_AMP_SECOND:   amp[0] = value;
                REG_AMP_THIRD:    amp[1] = value;
                REG_AMP_FOURTH:   amp[2] = value;
                REG_PHASE_SECOND: phs[0] = value;
                REG_PHASE_THIRD:  phs[1] = value;
                REG_PHASE_FOURTH: phs[2] = value;
                default: ;
            endcase
        endfunction

        // Quarter-wave sine, u in Q16 over a quarter turn, scaled to 32767.
        function longint quarter_sine(longint u);
            longint u2;
            longint p;
            longint s;
            longint q;
            u2 = (u * u) >>> 16;
            p = 64'sd172272;
            p = 64'sd5026995 - ((u2 * p) >>> 16);
            p = 64'sd85569306 - ((u2 * p) >>> 16);
            p = 64'sd693598343 - ((u2 * p) >>> 16);
            p = 64'sd1686629713 - ((u2 * p) >>> 16);
            s = (u * p) >>> 16;
            if (s < 0)
                s = 0;
            q = (s * 32767 + (64'sd1 << 29)) >>> 30;
            if (q > 32767)
                q = 32767;
            return q;
        endfunction

        function longint sine_at(logic [15:0] phase);
            logic [TABLE_BITS-1:0] slot;
            logic [1:0]            quad;
            longint                u;
            longint                v;
            slot = phase[15 -: TABLE_BITS];
            quad = slot[TABLE_BITS-1 -: 2];
            u = longint'(slot[TABLE_BITS-3:0]) << (16 - (TABLE_BITS - 2));
            if (quad[0])
                u = 65536 - u;
            v = quarter_sine(u);
            return quad[1] ? -v : v;
        endfunction

        function logic [15:0] order_phase(int order, logic [9:0] idx, logic [15:0] offset);
            longint ramp;
            ramp = (longint'(order) * longint'(idx) * 65536) / WAVE_POINTS;
            return 16'(ramp + longint'(offset));
        endfunction

        function logic [15:0] synth_code(logic [9:0] idx);
            int     count;
            longint acc;
            longint den;
            longint num;
            longint dd;
            longint q;
            longint code;
            longint s;
            count = int'(harm_count);
            if (count > HARMONIC_LIMIT)
                count = HARMONIC_LIMIT;
            acc = sine_at(order_phase(1, idx, base_phase)) * 4096;
            den = 4096;
            for (int k = 0; k < count; k++) begin
                s = sine_at(order_phase(k + 2, idx, phs[k]));
                acc += s * longint'(amp[k]);
                den += longint'(amp[k]);
            end
            num = acc * 32768;
            dd = den * 32767;
            if (num >= 0)
                q = num / dd;
            else
                q = -((-num + dd - 1) / dd);
            code = 32767 + q;
            if (code < 0)
                code = 0;
            if (code > 65535)
                code = 65535;
            return 16'(code);
        endfunction

        function void note_input(logic [15:0] tdata);
            owed_codes.push_back(synth_code(tdata[9:0]));
        endfunction

        function void check_result(logic [15:0] tdata);
            logic [15:0] want;
            if (owed_codes.size() == 0) begin
                $error("sample_code: unexpected result %0d", tdata);
                errors++;
                return;
            end
            want = owed_codes.pop_front();
            if (tdata !== want) begin
                $error("sample_code mismatch: expected %0d, actual %0d", want, tdata);
                errors++;
            end
        endfunction

        function int pending();
            return owed_codes.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = '0;
    logic [15:0] i_cfg_data    = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold     = 0;
    int quiet_cycles = 0;

    synth_scoreboard sb = new();

    harmonic_wave_sample_synth_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold = rx_hold - 1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Monitors and watchdog, all sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if ((i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready)
                    || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Valid stays high between back-to-back writes; the caller lowers it.
    task automatic cfg_write(logic [2:0] index, logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic drain();
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Reprograms the whole voice once every owed code has come out.
    task automatic set_voice(logic [15:0] base, logic [1:0] count,
                             logic [15:0] a2, logic [15:0] a3, logic [15:0] a4,
                             logic [15:0] p2, logic [15:0] p3, logic [15:0] p4);
        s_axis_tvalid <= 1'b0;
        drain();
        cfg_write(REG_BASE_PHASE, base);
        cfg_write(REG_HARM_COUNT, {14'($urandom), count});
        cfg_write(REG_AMP_SECOND, a2);
        cfg_write(REG_AMP_THIRD, a3);
        cfg_write(REG_AMP_FOURTH, a4);
        cfg_write(REG_PHASE_SECOND, p2);
        cfg_write(REG_PHASE_THIRD, p3);
        cfg_write(REG_PHASE_FOURTH, p4);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_index(logic [9:0] idx);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, idx};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [9:0] pick_index();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? 10'd1023 : 10'd0;
        return 10'($urandom_range(1023));
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fundamental alone at the quadrant boundaries and both index extremes.
        set_voice(16'd0, 2'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_index(10'd0);
        send_index(10'd1);
        send_index(10'd255);
        send_index(10'd256);
        send_index(10'd511);
        send_index(10'd512);
        send_index(10'd767);
        send_index(10'd768);
        send_index(10'd1023);

        // Every register at its top value, all harmonics on; phases wrap past a turn.
        set_voice(16'hFFFF, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_index(10'd0);
        send_index(10'd341);
        send_index(10'd512);
        send_index(10'd1000);
        send_index(10'd1023);

        // One harmonic on; the large amplitudes of the disabled ones must not count.
        set_voice(16'd0, 2'd1, 16'd4096, 16'hFFFF, 16'hFFFF, 16'd0, 16'd16384, 16'd32768);
        send_index(10'd0);
        send_index(10'd100);
        send_index(10'd900);

        set_voice(16'd12345, 2'd2, 16'd2048, 16'd8192, 16'd777, 16'd40000, 16'd1000, 16'hFFFF);
        send_index(10'd3);
        send_index(10'd700);
        send_index(10'd1023);

        // Negative full scale lands one below zero and saturates to code zero.
        set_voice(16'd49152, 2'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        send_index(10'd0);
        send_index(10'd512);

        for (int mode = 0; mode < 3; mode++) begin
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                set_voice(pick_word(), 2'($urandom_range(3)), pick_word(), pick_word(),
                          pick_word(), pick_word(), pick_word(), pick_word());
                tx_idle_pct = (mode == 0) ? 11 : (mode == 1) ? 62 : 0;
                rx_idle_pct = (mode == 0) ? 62 : (mode == 1) ? 11 : 0;
                // Stall the output long enough for the block to back up its input.
                if (mode == 2 && seg == 0)
                    rx_hold = 800;
                for (int n = 0; n < SEGMENT_ITEMS; n++)
                    send_index(pick_index());
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
hdl/hwss_pkg.sv
hdl/hwss_regs.sv
hdl/hwss_ctrl.sv
hdl/hwss_datapath.sv
hdl/harmonic_wave_sample_synth_top.sv
test/harmonic_wave_sample_synth_top_test.sv
